[rtl/core/slme_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slme_pkg
// Shared types for the sorted linked map engine: operation codes, result
// status codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package slme_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Source of the node store read address
  typedef enum logic [1:0] {
    RD_CUR  = 2'd0,
    RD_LINK = 2'd1,
    RD_FREE = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic    load;        // take the input word, restart the walk at the head
    rd_src_e rd_src;
    logic    advance;     // prev <= cur, cur <= link of cur
    logic    grab;        // key hit: keep old value and successor
    logic    wr_value;    // overwrite value of the hit node
    logic    reject;      // add refused, store full
    logic    take_fresh;  // new slot from the never-used range
    logic    take_free;   // new slot from the head of the free list
    logic    pop_free;    // free head <= link read of the taken slot
    logic    write_node;  // key, value and link of the new slot
    logic    link_new;    // predecessor (or head) points to the new slot
    logic    unlink;      // predecessor (or head) skips the hit node
    logic    release_node; // push the hit node onto the free list
    logic    finish;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cur_null;
    logic       key_eq;
    logic       key_before;
    logic       next_null;
    logic       full;
    logic       fresh_avail;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

[rtl/core/slme_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slme_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module slme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/slme_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slme_ctrl
// Sequencer for one operation: walk the list, then update links, the free
// list and the output register.
// ----------------------------------------------------------------------------
module slme_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire slme_pkg::sts_t sts_i,
  output      slme_pkg::cmd_t cmd_o
);
  import slme_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CMP,
    S_HIT,
    S_RELEASE,
    S_MISS,
    S_POP,
    S_NODE,
    S_LINK,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_src = RD_CUR;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        case (sts_i.op)
          OP_ADD, OP_SEARCH, OP_REMOVE: begin
            state_d = sts_i.cur_null ? S_MISS : S_CMP;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_CMP: begin
        if (sts_i.key_eq) begin
          cmd_o.grab = 1'b1;
          state_d    = S_HIT;
        end else if (sts_i.key_before) begin
          // step to the successor and read it right away
          cmd_o.advance = 1'b1;
          cmd_o.rd_src  = RD_LINK;
          state_d       = sts_i.next_null ? S_MISS : S_CMP;
        end else begin
          state_d = S_MISS;
        end
      end
      S_HIT: begin
        case (sts_i.op)
          OP_ADD: begin
            cmd_o.wr_value = 1'b1;
            state_d        = S_DONE;
          end
          OP_REMOVE: begin
            cmd_o.unlink = 1'b1;
            state_d      = S_RELEASE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RELEASE: begin
        cmd_o.release_node = 1'b1;
        state_d            = S_DONE;
      end
      S_MISS: begin
        if (sts_i.op == OP_ADD) begin
          if (sts_i.full) begin
            cmd_o.reject = 1'b1;
            state_d      = S_DONE;
          end else if (sts_i.fresh_avail) begin
            cmd_o.take_fresh = 1'b1;
            state_d          = S_NODE;
          end else begin
            cmd_o.take_free = 1'b1;
            cmd_o.rd_src    = RD_FREE;
            state_d         = S_POP;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP: begin
        cmd_o.pop_free   = 1'b1;
        cmd_o.write_node = 1'b1;
        state_d          = S_LINK;
      end
      S_NODE: begin
        cmd_o.write_node = 1'b1;
        state_d          = S_LINK;
      end
      S_LINK: begin
        cmd_o.link_new = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the word
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/slme_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slme_dp
// Datapath: node stores, list and free list pointers, pair count, key compare
// and the output register.
// ----------------------------------------------------------------------------
module slme_dp #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic [1:0]         operation_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               out_stall_i,
  output      logic               out_valid_o,
  output      logic signed [31:0] result_value_o,
  output      logic               found_o,
  output      logic               status_o,
  output      logic [4:0]         entry_count_o,
  output      logic               is_empty_o,
  input  wire slme_pkg::cmd_t     cmd_i,
  output      slme_pkg::sts_t     sts_o
);
  import slme_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic                order_q;
  logic [1:0]          op_q;
  logic signed [31:0]  key_q, val_q;
  logic [PW-1:0]       cur_q, prev_q, nxt_q, slot_q;
  logic [PW-1:0]       head_q, free_head_q;
  logic [CW-1:0]       fresh_q, count_q;
  logic signed [31:0]  res_q;
  logic                found_q, rej_q;

  logic signed [31:0]  key_rd, val_rd;
  logic [PW-1:0]       link_rd;
  logic [AW-1:0]       rd_addr;
  logic                out_valid_q;

  logic                link_we, val_we;
  logic [AW-1:0]       link_waddr, val_waddr;
  logic [PW-1:0]       link_wdata;
  logic signed [31:0]  val_wdata;
  logic                prev_null;

  assign prev_null = (prev_q == NIL);

  // read address
  always_comb begin
    case (cmd_i.rd_src)
      RD_LINK: rd_addr = link_rd[AW-1:0];
      RD_FREE: rd_addr = free_head_q[AW-1:0];
      default: rd_addr = cur_q[AW-1:0];
    endcase
  end

  // link store write port
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_q[AW-1:0];
    link_wdata = free_head_q;
    if (cmd_i.write_node) begin
      link_we    = 1'b1;
      link_waddr = slot_q[AW-1:0];
      link_wdata = cur_q;
    end else if (cmd_i.link_new) begin
      link_we    = !prev_null;
      link_waddr = prev_q[AW-1:0];
      link_wdata = slot_q;
    end else if (cmd_i.unlink) begin
      link_we    = !prev_null;
      link_waddr = prev_q[AW-1:0];
      link_wdata = nxt_q;
    end else if (cmd_i.release_node) begin
      link_we = 1'b1;
    end
  end

  assign val_we    = cmd_i.write_node | cmd_i.wr_value;
  assign val_waddr = cmd_i.write_node ? slot_q[AW-1:0] : cur_q[AW-1:0];
  assign val_wdata = val_q;

  slme_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_node),
    .waddr_i (slot_q[AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  slme_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  slme_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (rd_addr),
    .rdata_o (link_rd)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= 1'b0;
      head_q      <= NIL;
      free_head_q <= NIL;
      fresh_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (cmd_i.take_fresh) begin
        fresh_q <= fresh_q + CW'(1);
      end
      if (cmd_i.pop_free) begin
        free_head_q <= link_rd;
      end else if (cmd_i.release_node) begin
        free_head_q <= cur_q;
      end
      if (cmd_i.link_new && prev_null) begin
        head_q <= slot_q;
      end else if (cmd_i.unlink && prev_null) begin
        head_q <= nxt_q;
      end
      if (cmd_i.link_new) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.release_node) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers of the current word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      key_q   <= key_i;
      val_q   <= value_i;
      cur_q   <= head_q;
      prev_q  <= NIL;
      res_q   <= '0;
      found_q <= 1'b0;
      rej_q   <= STATUS_DONE;
    end
    if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q  <= link_rd;
    end
    if (cmd_i.grab) begin
      nxt_q   <= link_rd;
      res_q   <= val_rd;
      found_q <= 1'b1;
    end
    if (cmd_i.reject) begin
      rej_q <= STATUS_FULL;
    end
    if (cmd_i.take_fresh) begin
      slot_q <= PW'(fresh_q);
    end else if (cmd_i.take_free) begin
      slot_q <= free_head_q;
    end
    if (cmd_i.finish) begin
      result_value_o <= res_q;
      found_o        <= found_q;
      status_o       <= rej_q;
      entry_count_o  <= 5'(count_q);
      is_empty_o     <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.op          = op_q;
    sts_o.cur_null    = (cur_q == NIL);
    sts_o.key_eq      = (key_rd == key_q);
    sts_o.key_before  = order_q ? (key_rd >= key_q) : (key_rd <= key_q);
    sts_o.next_null   = (link_rd == NIL);
    sts_o.full        = (count_q >= CAP_CNT);
    sts_o.fresh_avail = (fresh_q < CAP_CNT);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

endmodule
`default_nettype wire

[rtl/core/sorted_linked_map_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_linked_map_engine
// Key/value map kept as a key-ordered singly linked list in node RAMs.
// ----------------------------------------------------------------------------
// One operation (add/update, search, remove) is in flight at a time; each
// accepted word yields exactly one result word. The walk reads one node per
// cycle from the key, value and link RAMs, then further states update links
// and the free list; an unused operation code skips the walk and goes
// straight to the result. A word is taken only while the controller is idle.
// A finished result sits in an output register, so the next word is taken
// while it waits; that next word then holds in its final state until the
// register is free. Unused slots are handed out first from a never-used
// range and then from a free list, so no clearing pass follows reset. An
// add of a new key into a full store is refused with status 1. The order
// bit written through cfg_we_i only changes how later walks compare; stored
// pairs are not reordered.
// ----------------------------------------------------------------------------
module sorted_linked_map_engine #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] value_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] result_value_o,
  output      logic               found_o,
  output      logic               status_o,
  output      logic [4:0]         entry_count_o,
  output      logic               is_empty_o
);
  import slme_pkg::*;

  cmd_t cmd;
  sts_t sts;

  slme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slme_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .result_value_o (result_value_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
`default_nettype wire

[tb/sv/slme_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slme_checker
// Watches the configuration, input and result channels of the sorted linked
// map engine, keeps its own ordered list model and compares each result word
// with the oldest prediction.
// ----------------------------------------------------------------------------
module slme_checker #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [1:0]         operation_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic signed [31:0] result_value_i,
  input  wire logic               found_i,
  input  wire logic               status_i,
  input  wire logic [4:0]         entry_count_i,
  input  wire logic               is_empty_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  import slme_pkg::*;

  localparam int NIL = CAPACITY;

  typedef struct {
    logic signed [31:0] value;
    logic               found;
    logic               status;
    logic [4:0]         count;
    logic               empty;
  } map_result_t;

  map_result_t        result_q[$];
  logic signed [31:0] node_key[CAPACITY];
  logic signed [31:0] node_val[CAPACITY];
  int                 node_link[CAPACITY];
  int                 list_first;
  int                 free_first;
  int                 pairs;
  logic               descending;
  int                 mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic bit key_at_or_before(logic signed [31:0] a, logic signed [31:0] b);
    return descending ? (a >= b) : (a <= b);
  endfunction

  function automatic map_result_t apply_map_op(logic [1:0] op, logic signed [31:0] k,
                                               logic signed [31:0] v);
    map_result_t r;
    int          cur;
    int          prev;
    int          steps;
    int          slot;
    bit          hit;
    r.value  = '0;
    r.found  = 1'b0;
    r.status = STATUS_DONE;
    cur      = list_first;
    prev     = NIL;
    steps    = 0;
    hit      = 1'b0;
    if (op == OP_ADD || op == OP_SEARCH || op == OP_REMOVE) begin
      // walk while nodes stand before or at the key in the current order
      while (cur < NIL && steps < NIL && key_at_or_before(node_key[cur], k)) begin
        if (node_key[cur] == k) begin
          hit = 1'b1;
          break;
        end
        prev = cur;
        cur  = node_link[cur];
        steps++;
      end
      if (hit) begin
        r.found = 1'b1;
        r.value = node_val[cur];
        if (op == OP_ADD) begin
          node_val[cur] = v;
        end else if (op == OP_REMOVE) begin
          if (prev == NIL) list_first = node_link[cur];
          else node_link[prev] = node_link[cur];
          node_link[cur] = free_first;
          free_first     = cur;
          if (pairs > 0) pairs--;
        end
      end else if (op == OP_ADD) begin
        if (free_first >= NIL || pairs >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          slot            = free_first;
          free_first      = node_link[slot];
          node_key[slot]  = k;
          node_val[slot]  = v;
          node_link[slot] = cur;
          if (prev == NIL) list_first = slot;
          else node_link[prev] = slot;
          pairs++;
        end
      end
    end
    r.count = pairs[4:0];
    r.empty = (pairs == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        node_key[i]  = '0;
        node_val[i]  = '0;
        node_link[i] = i + 1;
      end
      list_first = NIL;
      free_first = 0;
      pairs      = 0;
      descending = 1'b0;
      mismatches = 0;
      result_q.delete();
      pending_o  = 0;
    end else begin
      // results come from earlier words, so check before predicting this edge's word
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected word", result_value_i, '0);
        end else begin
          want = result_q.pop_front();
          if (result_value_i !== want.value)
            report_mismatch("result_value", result_value_i, want.value);
          if (found_i !== want.found) report_mismatch("found", found_i, want.found);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (entry_count_i !== want.count)
            report_mismatch("entry_count", entry_count_i, want.count);
          if (is_empty_i !== want.empty) report_mismatch("is_empty", is_empty_i, want.empty);
        end
      end
      if (in_valid_i && !in_stall_i)
        result_q.push_back(apply_map_op(operation_i, key_i, value_i));
      if (cfg_we_i) descending = cfg_wdata_i;
      pending_o = result_q.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sorted linked map engine with directed corner cases and random
// add/search/remove bursts over a small key pool, in both key orders and
// under varying sender and receiver idling; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import slme_pkg::*;

  localparam int               CAPACITY     = 16;
  localparam int               CYCLE_LIMIT  = 200000;
  localparam int               HOLD_CYCLES  = 300;
  localparam int               POOL_SIZE    = 24;
  localparam int               PHASE_ITEMS  = 135;
  localparam int               BURST_LEN    = 30;
  localparam logic [1:0]       OP_UNUSED    = 2'd3;
  localparam logic signed [31:0] KEY_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX    = 32'sh7fff_ffff;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic               cfg_wdata_i    = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i    = OP_SEARCH;
  logic signed [31:0] key_i          = '0;
  logic signed [31:0] value_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b1;
  logic signed [31:0] result_value_o;
  logic               found_o;
  logic               status_o;
  logic [4:0]         entry_count_o;
  logic               is_empty_o;

  int                 fail_count;
  int                 pending;
  int                 cycle_count    = 0;
  int                 tx_idle_pct    = 0;
  int                 rx_idle_pct    = 0;
  bit                 pressure_req   = 1'b0;
  bit                 pressure_done  = 1'b0;
  int                 hold_left      = 0;
  logic signed [31:0] key_pool[POOL_SIZE];

  always #5 clk_i = ~clk_i;

  sorted_linked_map_engine #(.CAPACITY(CAPACITY)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .operation_i, .key_i, .value_i,
    .out_valid_o, .out_stall_i, .result_value_o, .found_o, .status_o,
    .entry_count_o, .is_empty_o
  );

  slme_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .key_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_value_i(result_value_o),
    .found_i(found_o), .status_i(status_o), .entry_count_i(entry_count_o),
    .is_empty_i(is_empty_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall, plus one long hold-off when asked
  always @(negedge clk_i) begin
    if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES - 1;
      out_stall_i   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_linked_map_engine] ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic signed [31:0] k,
                           input logic signed [31:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= k;
    value_i     <= v;
    // hold the word until taken
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic set_order(input logic desc);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random_phase(input int n_items);
    logic [1:0]         op;
    logic signed [31:0] k;
    int                 r;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      // alternate fill-heavy and drain-heavy bursts to reach full and empty
      if ((i / BURST_LEN) % 2 == 0) begin
        op = (r < 60) ? OP_ADD : (r < 80) ? OP_SEARCH : (r < 96) ? OP_REMOVE : OP_UNUSED;
      end else begin
        op = (r < 20) ? OP_ADD : (r < 45) ? OP_SEARCH : (r < 95) ? OP_REMOVE : OP_UNUSED;
      end
      if ($urandom_range(99) < 80) k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else k = $urandom;
      send_word(op, k, $urandom);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 20;
    rx_idle_pct = 46;

    // empty map, extremes, update, remove of absent key
    send_word(OP_SEARCH, '0, 32'sd7);
    send_word(OP_REMOVE, '0, '0);
    send_word(OP_UNUSED, 32'sd5, 32'sd5);
    send_word(OP_ADD, KEY_MIN, KEY_MAX);
    send_word(OP_ADD, KEY_MAX, KEY_MIN);
    send_word(OP_ADD, '0, -32'sd1);
    send_word(OP_ADD, -32'sd1, '0);
    send_word(OP_SEARCH, -32'sd1, '0);
    send_word(OP_ADD, -32'sd1, 32'sh5555_5555);
    send_word(OP_REMOVE, '0, '0);
    send_word(OP_REMOVE, '0, '0);
    // fill to capacity, then a rejected add and an update while full
    for (int i = 0; i < 13; i++) send_word(OP_ADD, i * 37 - 200, $urandom);
    send_word(OP_ADD, 32'sd9999, 32'sd1);
    send_word(OP_ADD, KEY_MIN, 32'shAAAA_AAAA);
    send_word(OP_UNUSED, KEY_MAX, '0);

    set_order(1'b1);
    run_random_phase(PHASE_ITEMS);

    set_order(1'b0);
    tx_idle_pct = 46;
    rx_idle_pct = 20;
    run_random_phase(PHASE_ITEMS);

    set_order(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pressure_req = 1'b1;
    run_random_phase(PHASE_ITEMS);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[sorted_linked_map_engine] OK");
    end else begin
      $display("[sorted_linked_map_engine] ERROR");
    end
    $finish;
  end

endmodule
